@@ rtl/plct_pkg.sv @@
// Shared types and constants for the piecewise linear curve table.
package plct_pkg;
   localparam int MaxPoints = 32;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int ValW = 16;

   typedef enum logic [1:0] {
      CMD_EVAL = 2'd0, CMD_INSERT = 2'd1, CMD_REMOVE = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic           rd;
      logic [IdxW-1:0] rd_addr;
      logic           wr;
      logic [IdxW-1:0] wr_addr;
      logic           wr_sel_new;
      logic           cap_p;
      logic           cap_c;
      logic           div_start;
   } dp_cmd_type;

   typedef struct packed {
      logic            [ValW-1:0] rd_x;
      logic            [ValW-1:0] rd_y;
      logic            div_done;
   } dp_stat_type;
endpackage

@@ rtl/plct_datapath.sv @@
// Breakpoint memories, segment registers and a serial divider.
module plct_datapath import plct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [ValW-1:0]   new_x,
   input  logic [ValW-1:0]   new_y,
   input  logic [ValW-1:0]   eval_x,
   output dp_stat_type       stat,
   output logic [ValW-1:0]   interp
);
   localparam int QW = 2 * ValW;
   logic [ValW-1:0] mem_x [MaxPoints];
   logic [ValW-1:0] mem_y [MaxPoints];
   logic [ValW-1:0] rdx_ff, rdy_ff;
   logic [ValW-1:0] wx_in, wy_in;
   logic signed [ValW-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic [QW-1:0] num_ff, num_in, rem_ff, rem_in;
   logic [ValW:0] den_ff;
   logic [5:0] bit_ff;
   logic busy_ff, done_ff, neg_ff;
   logic signed [ValW:0] dy;
   logic [ValW:0] mag_dy, dx_num, dx_den;
   logic [QW:0] trial;

   assign wx_in = cmd.wr_sel_new ? new_x : rdx_ff;
   assign wy_in = cmd.wr_sel_new ? new_y : rdy_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem_x[cmd.wr_addr] <= wx_in;
         mem_y[cmd.wr_addr] <= wy_in;
      end
      if (cmd.rd) begin
         rdx_ff <= mem_x[cmd.rd_addr];
         rdy_ff <= mem_y[cmd.rd_addr];
      end
   end

   assign stat.rd_x = rdx_ff;
   assign stat.rd_y = rdy_ff;
   assign stat.div_done = done_ff;

   assign dy = {cy_ff[ValW-1], cy_ff} - {py_ff[ValW-1], py_ff};
   assign mag_dy = dy[ValW] ? -dy : dy;
   assign dx_num = {eval_x[ValW-1], eval_x} - {px_ff[ValW-1], px_ff};
   assign dx_den = {cx_ff[ValW-1], cx_ff} - {px_ff[ValW-1], px_ff};
   assign trial = {rem_ff, num_ff[QW-1]} - {{(QW-ValW){1'b0}}, den_ff};
   assign num_in = {num_ff[QW-2:0], ~trial[QW]};
   assign rem_in = trial[QW] ? {rem_ff[QW-2:0], num_ff[QW-1]} : trial[QW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.cap_p) begin
         px_ff <= rdx_ff;
         py_ff <= rdy_ff;
      end
      if (cmd.cap_c) begin
         cx_ff <= rdx_ff;
         cy_ff <= rdy_ff;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else if (cmd.div_start) begin
         num_ff  <= QW'(mag_dy) * QW'(dx_num);
         den_ff  <= dx_den;
         rem_ff  <= '0;
         neg_ff  <= dy[ValW];
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         bit_ff <= bit_ff + 6'd1;
         if (bit_ff == 6'(QW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign interp = neg_ff ? py_ff - num_ff[ValW-1:0] : py_ff + num_ff[ValW-1:0];
endmodule

@@ rtl/plct_ctrl.sv @@
// Command sequencer: search, shift, interpolate and respond.
module plct_ctrl import plct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_cmd,
   input  logic [ValW-1:0]   req_x,
   input  logic [IdxW-1:0]   req_index,
   input  dp_stat_type       stat,
   input  logic [ValW-1:0]   interp,
   output dp_cmd_type        cmd,
   output logic [ValW-1:0]   eval_x,
   output logic              rsp_valid,
   output logic [ValW-1:0]   rsp_value,
   output logic [1:0]        rsp_status,
   output logic [CntW-1:0]   rsp_point_count
);
   typedef enum logic [3:0] {
      IDLE, SRCH_RD, SRCH_CHK, INS_SH_RD, INS_SH_WR, INS_WR,
      REM_RD, REM_WR, EV_PREV, EV_CAPP, EV_START, EV_DIV, DONE
   } state_type;

   state_type state_ff;
   logic [1:0] cmd_ff;
   logic [ValW-1:0] x_ff;
   logic [CntW-1:0] cnt_ff, ptr_ff, pos_ff;
   logic [ValW-1:0] val_ff;
   logic [1:0] st_ff;
   logic rv_ff;
   logic eq_ff;
   logic le;

   assign busy = state_ff != IDLE;
   assign eval_x = x_ff;
   assign le = $signed(stat.rd_x) <= $signed(x_ff);
   assign rsp_valid = rv_ff;
   assign rsp_value = val_ff;
   assign rsp_status = st_ff;
   assign rsp_point_count = cnt_ff;

   always_comb begin
      cmd = '0;
      cmd.rd_addr = ptr_ff[IdxW-1:0];
      cmd.wr_addr = ptr_ff[IdxW-1:0];
      case (state_ff)
         SRCH_RD, INS_SH_RD, REM_RD, EV_PREV: cmd.rd = 1'b1;
         INS_SH_WR, REM_WR: cmd.wr = 1'b1;
         INS_WR: begin
            cmd.wr = 1'b1;
            cmd.wr_sel_new = 1'b1;
            cmd.wr_addr = pos_ff[IdxW-1:0];
         end
         EV_CAPP: cmd.cap_p = 1'b1;
         SRCH_CHK: cmd.cap_c = 1'b1;
         EV_START: cmd.div_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         case (state_ff)
            IDLE: if (start) begin
               cmd_ff <= req_cmd;
               x_ff <= req_x;
               ptr_ff <= '0;
               val_ff <= '0;
               eq_ff <= 1'b0;
               st_ff <= ST_OK;
               case (cmd_type'(req_cmd))
                  CMD_EVAL: if (cnt_ff == 0) begin
                     st_ff <= ST_EMPTY;
                     state_ff <= DONE;
                  end else state_ff <= SRCH_RD;
                  CMD_INSERT: if (cnt_ff == CntW'(MaxPoints)) begin
                     st_ff <= ST_FULL;
                     state_ff <= DONE;
                  end else if (cnt_ff == 0) begin
                     pos_ff <= '0;
                     state_ff <= INS_WR;
                  end else state_ff <= SRCH_RD;
                  CMD_REMOVE: if (CntW'(req_index) >= cnt_ff) begin
                     st_ff <= ST_INDEX;
                     state_ff <= DONE;
                  end else begin
                     ptr_ff <= CntW'(req_index) + 1'b1;
                     state_ff <= REM_RD;
                  end
                  default: state_ff <= DONE;
               endcase
            end
            SRCH_RD: state_ff <= SRCH_CHK;
            SRCH_CHK: begin
               if (cmd_ff == CMD_INSERT) begin
                  if (!le || ptr_ff == cnt_ff - 1'b1) begin
                     pos_ff <= le ? ptr_ff + 1'b1 : ptr_ff;
                     if (!le) begin
                        ptr_ff <= cnt_ff - 1'b1;
                        state_ff <= INS_SH_RD;
                     end else state_ff <= INS_WR;
                  end else begin
                     ptr_ff <= ptr_ff + 1'b1;
                     state_ff <= SRCH_RD;
                  end
               end else if (ptr_ff == '0 && stat.rd_x == x_ff) begin
                  val_ff <= stat.rd_y;
                  state_ff <= DONE;
               end else if (le && ptr_ff != cnt_ff - 1'b1) begin
                  // The first breakpoint equal to x answers unless x is also the last x.
                  if (stat.rd_x == x_ff && !eq_ff) begin
                     eq_ff <= 1'b1;
                     val_ff <= stat.rd_y;
                  end
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= SRCH_RD;
               end else if (le || ptr_ff == 0) begin
                  val_ff <= stat.rd_y;
                  state_ff <= DONE;
               end else if (eq_ff) begin
                  state_ff <= DONE;
               end else begin
                  ptr_ff <= ptr_ff - 1'b1;
                  state_ff <= EV_PREV;
               end
            end
            INS_SH_RD: state_ff <= INS_SH_WR;
            INS_SH_WR: if (ptr_ff == pos_ff) state_ff <= INS_WR;
            else begin
               ptr_ff <= ptr_ff - 1'b1;
               state_ff <= INS_SH_RD;
            end
            INS_WR: begin
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= DONE;
            end
            REM_RD: if (ptr_ff == cnt_ff) begin
               cnt_ff <= cnt_ff - 1'b1;
               state_ff <= DONE;
            end else state_ff <= REM_WR;
            REM_WR: state_ff <= REM_RD;
            EV_PREV: state_ff <= EV_CAPP;
            EV_CAPP: state_ff <= EV_START;
            EV_START: state_ff <= EV_DIV;
            EV_DIV: if (stat.div_done) begin
               val_ff <= interp;
               state_ff <= DONE;
            end
            DONE: begin
               rv_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
         if (state_ff == REM_WR) ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // Shift writes target ptr+1 for insert and ptr-1 for remove.
   // Handled by an address offset in the top level.

   assert property (@(posedge clock) disable iff (reset) rv_ff |=> !rv_ff);
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntW'(MaxPoints));
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == INS_WR) |=> cnt_ff == $past(cnt_ff) + 1'b1);
endmodule

@@ rtl/piecewise_linear_curve_table_core.sv @@
// Top level of the piecewise linear curve table.
// A request is taken when start is high and busy is low; it carries req_cmd
// (0 evaluate, 1 insert, 2 remove), req_x, req_y and req_index.
// Exactly one response follows per request: rsp_valid is high for one cycle
// with rsp_value, rsp_status and rsp_point_count, and must be taken then.
// Breakpoints live in two 32-entry memories with one read and one write port.
// Evaluate walks the breakpoints in order; when x falls between two of them,
// a 32-step serial divider interpolates the result. Insert searches for the
// position and shifts the later entries up before it writes. Remove shifts
// the tail down. Errors and the unused command answer without a search.
// A new request can be taken at the edge that takes the response.
// Synchronous reset empties the table; no clearing pass is needed.
// Busy stays high until the response has been issued.
module piecewise_linear_curve_table_core import plct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_cmd,
   input  logic signed [ValW-1:0] req_x,
   input  logic signed [ValW-1:0] req_y,
   input  logic [IdxW-1:0]   req_index,
   output logic              rsp_valid,
   output logic signed [ValW-1:0] rsp_value,
   output logic [1:0]        rsp_status,
   output logic [CntW-1:0]   rsp_point_count
);
   dp_cmd_type  c, cadj;
   dp_stat_type s;
   logic [ValW-1:0] ex, ip, ny_ff;
   logic ins_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         ny_ff <= req_y;
         ins_ff <= req_cmd == CMD_INSERT;
      end
   end

   always_comb begin
      cadj = c;
      if (c.wr && !c.wr_sel_new)
         cadj.wr_addr = ins_ff ? c.wr_addr + 1'b1 : c.wr_addr - 1'b1;
   end

   plct_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .req_cmd, .req_x, .req_index,
      .stat(s), .interp(ip), .cmd(c), .eval_x(ex), .rsp_valid, .rsp_value,
      .rsp_status, .rsp_point_count
   );

   plct_datapath u_dp (
      .clock, .reset, .cmd(cadj), .new_x(ex), .new_y(ny_ff), .eval_x(ex),
      .stat(s), .interp(ip)
   );
endmodule
